// File: src/hashed_table_depth_replace_top_assert.svh
// ---------------------------------------------------------------------------
// hashed table assertion macros
// clocked on clk_i and disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef HASHED_TABLE_DEPTH_REPLACE_TOP_ASSERT_SVH
`define HASHED_TABLE_DEPTH_REPLACE_TOP_ASSERT_SVH

// plain property, checked at every edge out of reset
`define HTDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent this cycle, consequent from the next cycle on
`define HTDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/htdr_pkg.sv
// ---------------------------------------------------------------------------
// htdr_pkg
// shared types and constants of the depth-preferred hashed table
// ---------------------------------------------------------------------------
package htdr_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int KEY_W       = 64;
  localparam int TAG_W       = KEY_W - INDEX_BITS;
  localparam int SCORE_W     = 32;
  localparam int DEPTH_W     = 8;
  localparam int KIND_W      = 2;

  localparam int S_TDATA_W   = 112;
  localparam int M_TDATA_W   = 48;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_STORE  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;

  // classified request as it travels from front to back
  typedef struct packed {
    logic                     store;
    logic [INDEX_BITS-1:0]    index;
    logic [TAG_W-1:0]         tag;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]       depth;
    logic [KIND_W-1:0]        kind;
  } req_t;

  // one table entry; the full key is kept since a cleared entry holds key zero
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [KIND_W-1:0]         kind;
  } entry_t;

  typedef struct packed {
    logic                      hit;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [KIND_W-1:0]         kind;
    logic                      written;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READ,
    ST_EVAL
  } bstate_e;

endpackage

// File: src/htdr_front.sv
// ---------------------------------------------------------------------------
// htdr_front
// input register: accepts requests, splits the key into index and tag
// ---------------------------------------------------------------------------
module htdr_front
  import htdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clearing_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_cmd_i,
  input  logic [KEY_W-1:0]   in_key_i,
  input  logic [SCORE_W-1:0] in_score_i,
  input  logic [DEPTH_W-1:0] in_depth_i,
  input  logic [KIND_W-1:0]  in_kind_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output req_t        push_data_o
);

  logic vld_q, vld_d;
  req_t req_q, req_d;
  logic take;

  // no requests while the table sweep is running
  assign in_ready_o = !clearing_i && (!vld_q || push_ready_i);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    req_d       = req_q;
    vld_d       = vld_q;
    if (push_ready_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d       = 1'b1;
      req_d.store = (in_cmd_i == CMD_STORE);
      req_d.index = in_key_i[INDEX_BITS-1:0];
      req_d.tag   = in_key_i[KEY_W-1:INDEX_BITS];
      req_d.score = in_score_i;
      req_d.depth = in_depth_i;
      req_d.kind  = in_kind_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign push_valid_o = vld_q;
  assign push_data_o  = req_q;

endmodule

// File: src/htdr_queue.sv
// ---------------------------------------------------------------------------
// htdr_queue
// short request queue decoupling the front from the table engine
// ---------------------------------------------------------------------------
module htdr_queue
  import htdr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  req_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output req_t pop_data_o
);

  req_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/htdr_back.sv
// ---------------------------------------------------------------------------
// htdr_back
// table engine: clearing sweep, read, compare and replacement write-back
// ---------------------------------------------------------------------------
module htdr_back
  import htdr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  output logic    clearing_o,
  input  logic    pop_valid_i,
  output logic    pop_ready_o,
  input  req_t    pop_data_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  entry_t mem [TABLE_DEPTH];

  bstate_e               state_q, state_d;
  logic [INDEX_BITS-1:0] clr_cnt_q, clr_cnt_d;
  req_t                  cur_q, cur_d;
  entry_t                rd_q;
  logic                  out_vld_q, out_vld_d;
  result_t               out_q, out_d;

  logic                  rd_en;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  entry_t                wr_data;
  logic                  hit;
  logic                  accept;

  assign hit = (rd_q.key == {cur_q.tag, cur_q.index});

  // depth-preferred rule; a differing key is always replaced
  always_comb begin
    priority if (!hit) begin
      accept = 1'b1;
    end else if (rd_q.kind == KIND_EMPTY) begin
      accept = 1'b1;
    end else if (cur_q.depth > rd_q.depth) begin
      accept = 1'b1;
    end else if (cur_q.depth == rd_q.depth && rd_q.kind == KIND_EXACT) begin
      accept = 1'b1;
    end else begin
      accept = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cur_q.index;
    wr_data     = '{key: {cur_q.tag, cur_q.index}, score: cur_q.score, depth: cur_q.depth,
                    kind: cur_q.kind};
    pop_ready_o = 1'b0;

    if (out_vld_q && res_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        wr_data   = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == {INDEX_BITS{1'b1}}) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // only start when the result register will be free at evaluation
        pop_ready_o = !out_vld_q || res_ready_i;
        if (pop_valid_i && pop_ready_o) begin
          rd_en   = 1'b1;
          cur_d   = pop_data_i;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        wr_en         = cur_q.store && accept;
        out_vld_d     = 1'b1;
        out_d.hit     = hit;
        out_d.score   = hit ? rd_q.score : '0;
        out_d.depth   = hit ? rd_q.depth : '0;
        out_d.kind    = hit ? rd_q.kind  : KIND_EMPTY;
        out_d.written = cur_q.store && accept;
        state_d       = ST_READ;
      end
      default: begin
        state_d = ST_READ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[pop_data_i.index];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: src/hashed_table_depth_replace_top.sv
// path: front register, request queue, then the back-end ST_READ and ST_EVAL states, whose
//   result register drives m_axis_tdata; a request is popped only in ST_READ, so the engine
//   takes no new request before the last one's read and write-back of the table memory end
// reset: async active low; afterwards a sweep zeroes all 2^INDEX_BITS (65536) table entries,
//   and s_axis_tready stays low until it ends
// ---------------------------------------------------------------------------
// hashed_table_depth_replace_top
// direct-mapped hashed table with depth-preferred replacement
// ---------------------------------------------------------------------------
module hashed_table_depth_replace_top
  import htdr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // hash_key[63:0], score[95:64], search_depth[103:96], bound_kind[105:104], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // hit[0], found_score[32:1], found_depth[40:33], found_kind[42:41], written[43], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

`include "hashed_table_depth_replace_top_assert.svh"

  logic    clearing;
  logic    push_valid, push_ready;
  req_t    push_data;
  logic    pop_valid, pop_ready;
  req_t    pop_data;
  result_t res;

  htdr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_i   (clearing),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_key_i     (s_axis_tdata[63:0]),
    .in_score_i   (s_axis_tdata[95:64]),
    .in_depth_i   (s_axis_tdata[103:96]),
    .in_kind_i    (s_axis_tdata[105:104]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  htdr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  htdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {4'b0000, res.written, res.kind, res.depth, res.score, res.hit};

  `HTDR_ASSERT(a_no_req_during_clear, clearing |-> !s_axis_tready, "request taken during sweep")
  `HTDR_ASSERT(a_queue_empty_after_clear, $fell(clearing) |-> !pop_valid, "queue busy at sweep end")
  `HTDR_ASSERT_NEXT(a_pop_gives_result, pop_valid && pop_ready,
                    !m_axis_tvalid ##1 m_axis_tvalid, "popped request gave no result")

endmodule
